/* hdl/keypad_debounce_event_latch_unit_defines.svh */
// Assertion macros for the keypad debounce and event latch unit
`ifndef KEYPAD_DEBOUNCE_EVENT_LATCH_UNIT_DEFINES_SVH
`define KEYPAD_DEBOUNCE_EVENT_LATCH_UNIT_DEFINES_SVH

// check that cons holds in the same cycle as ante
`define KDEL_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kdel: same-cycle check failed");

// check that cons holds in the cycle after ante
`define KDEL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kdel: next-cycle check failed");

`endif

/* hdl/kdel_pkg.sv */
// Types and constants shared by the keypad debounce and event latch unit
package kdel_pkg;

  localparam int ROWS = 4;
  localparam int ROWS_MAX = 4;
  localparam int KEY_BITS = 18;
  localparam int BTN_A_BIT = 16;
  localparam int BTN_B_BIT = 17;

  localparam logic [1:0] ACT_SCAN = 2'd0;
  localparam logic [1:0] ACT_READ_EVENT = 2'd1;
  localparam logic [1:0] ACT_CLEAR_ALL = 2'd2;

  localparam logic REG_STABLE_TICKS = 1'b0;
  localparam logic [3:0] STABLE_TICKS_RESET = 4'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [15:0] matrix_levels;
    logic button_a_level;
    logic button_b_level;
    logic [4:0] key_index;
  } req_t;

  typedef struct packed {
    logic press_event;
    logic key_down;
    logic [KEY_BITS-1:0] key_state;
  } rsp_t;

endpackage

/* hdl/kdel_cfg.sv */
// APB-style configuration register for the debounce count
module kdel_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  stable_ticks
);

  logic reg_hit;

  assign reg_hit = (paddr[2] == kdel_pkg::REG_STABLE_TICKS);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_ticks <= kdel_pkg::STABLE_TICKS_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      stable_ticks <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (reg_hit) begin
      prdata = {28'd0, stable_ticks};
    end
  end

endmodule

/* hdl/kdel_core.sv */
// Debounce state, press event latch and result formation
module kdel_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  kdel_pkg::req_t    req,
  input  logic [3:0]        stable_ticks,
  output kdel_pkg::rsp_t    rsp_next
);

  logic [kdel_pkg::KEY_BITS-1:0] accepted_map, accepted_map_next;
  logic [kdel_pkg::KEY_BITS-1:0] pending_events, pending_events_next;
  logic [kdel_pkg::KEY_BITS-1:0] previous_raw, previous_raw_next;
  logic [3:0] stable_count, stable_count_next;
  logic [kdel_pkg::KEY_BITS-1:0] raw;
  logic [kdel_pkg::KEY_BITS-1:0] key_mask;
  logic [4:0] count_inc;
  logic event_hit;

  always_comb begin
    raw = '0;
    for (int r = 0; r < kdel_pkg::ROWS_MAX; r++) begin
      if (r < kdel_pkg::ROWS) begin
        raw[r*4 +: 4] = ~req.matrix_levels[r*4 +: 4];
      end
    end
    raw[kdel_pkg::BTN_A_BIT] = ~req.button_a_level;
    raw[kdel_pkg::BTN_B_BIT] = ~req.button_b_level;
  end

  assign key_mask = (req.key_index < 5'(kdel_pkg::KEY_BITS)) ?
                    (kdel_pkg::KEY_BITS'(1) << req.key_index) : '0;
  assign count_inc = {1'b0, stable_count} + 5'd1;
  assign event_hit = |(pending_events & key_mask);

  always_comb begin
    accepted_map_next = accepted_map;
    pending_events_next = pending_events;
    previous_raw_next = previous_raw;
    stable_count_next = stable_count;
    case (req.action)
      kdel_pkg::ACT_SCAN: begin
        if (raw == previous_raw) begin
          if (count_inc >= {1'b0, stable_ticks}) begin
            stable_count_next = stable_ticks;
            if (accepted_map != raw) begin
              pending_events_next = pending_events | (raw & ~accepted_map);
              accepted_map_next = raw;
            end
          end else begin
            stable_count_next = count_inc[3:0];
          end
        end else begin
          stable_count_next = '0;
          previous_raw_next = raw;
        end
      end
      kdel_pkg::ACT_READ_EVENT: begin
        pending_events_next = pending_events & ~key_mask;
      end
      kdel_pkg::ACT_CLEAR_ALL: begin
        pending_events_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_next.press_event = (req.action == kdel_pkg::ACT_READ_EVENT) && event_hit;
    rsp_next.key_down = |(accepted_map_next & key_mask);
    rsp_next.key_state = accepted_map_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_map <= '0;
      pending_events <= '0;
      previous_raw <= '0;
      stable_count <= '0;
    end else if (fire) begin
      accepted_map <= accepted_map_next;
      pending_events <= pending_events_next;
      previous_raw <= previous_raw_next;
      stable_count <= stable_count_next;
    end
  end

endmodule

/* hdl/keypad_debounce_event_latch_unit.sv */
// Top level of the keypad debounce and event latch unit
// Takes one request per clock cycle while req_stall is low; each accepted request
// passes the input register, then the combinational debounce and event update,
// then the result register. The input register holds a request only while the
// result register is full and stalled. stable_ticks sits at byte address 0 of the
// configuration port and resets to 2.
`include "keypad_debounce_event_latch_unit_defines.svh"

module keypad_debounce_event_latch_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  kdel_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output kdel_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic pipe_valid;
  kdel_pkg::req_t pipe_req;
  kdel_pkg::rsp_t rsp_next;
  logic [3:0] stable_ticks;
  logic advance;
  logic pipe_fire;
  logic req_accept;

  assign advance = !rsp_valid || !rsp_stall;
  assign pipe_fire = pipe_valid && advance;
  assign req_stall = pipe_valid && !advance;
  assign req_accept = req_valid && !req_stall;

  kdel_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .stable_ticks (stable_ticks)
  );

  kdel_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (pipe_fire),
    .req          (pipe_req),
    .stable_ticks (stable_ticks),
    .rsp_next     (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (req_accept) begin
      pipe_valid <= 1'b1;
    end else if (pipe_fire) begin
      pipe_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      pipe_req <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pipe_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_fire) begin
      rsp <= rsp_next;
    end
  end

  `KDEL_ASSERT_IMPLY(a_stall_when_blocked, pipe_valid && rsp_valid && rsp_stall, req_stall)
  `KDEL_ASSERT_NEXT(a_fire_fills_result, pipe_fire, rsp_valid)
  `KDEL_ASSERT_NEXT(a_cfg_write_lands, psel && penable && pwrite && !paddr[2],
    stable_ticks == $past(pwdata[3:0]))

endmodule
